FILE: hdl/bde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_pkg
// Shared sizes, operation codes, command type and ring helpers of the
// bounded deque engine.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int DEPTH         = 16;
    localparam int ELEMENT_WIDTH = 32;

    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int INDEX_W = 4;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W   = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd5;
    localparam logic [KIND_W-1:0] KIND_GET        = 3'd6;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd7;

    typedef logic [ELEMENT_WIDTH-1:0] t_elem;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               scan;   // remove or find: walks the stored elements
        t_elem              key;
        logic [INDEX_W-1:0] index;
    } t_cmd;

    // (base + offset) mod DEPTH; base < DEPTH and offset <= DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [COUNT_W-1:0] offset);
        logic [COUNT_W:0] sum;
        sum = (COUNT_W + 1)'(base) + (COUNT_W + 1)'(offset);
        if (sum >= (COUNT_W + 1)'(DEPTH)) begin
            sum = sum - (COUNT_W + 1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] res;
        if (base == '0) begin
            res = ADDR_W'(DEPTH - 1);
        end else begin
            res = base - 1'b1;
        end
        return res;
    endfunction

    function automatic t_elem to_elem(input logic [WORD_W-1:0] word);
        return ELEMENT_WIDTH'(word);
    endfunction

    function automatic logic [WORD_W-1:0] to_word(input t_elem elem);
        return WORD_W'(elem);
    endfunction

endpackage

FILE: hdl/bde_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_front
// Accepts items, classifies them into commands and holds them in a two-entry
// queue ahead of the execution sequencer.
// ----------------------------------------------------------------------------
module bde_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [bde_pkg::KIND_W-1:0]    i_kind,
    input  logic [bde_pkg::WORD_W-1:0]    i_value,
    input  logic [bde_pkg::INDEX_W-1:0]   i_index,
    output logic                          o_cmd_valid,
    output bde_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_take
);
    import bde_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        w_cmd.kind  = i_kind;
        w_cmd.scan  = (i_kind == KIND_REMOVE) || (i_kind == KIND_FIND);
        w_cmd.key   = to_elem(i_value);
        w_cmd.index = i_index;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wp  = w_wr ? ~r_wp : r_wp;
        n_rp  = w_rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

FILE: hdl/bde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_back
// Execution sequencer: carries out one command at a time on the ring held in
// the slot RAM, then reads front and rear and posts the result register.
// ----------------------------------------------------------------------------
module bde_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  bde_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_take,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_ok,
    output logic [bde_pkg::WORD_W-1:0]    o_read_value,
    output logic [bde_pkg::WORD_W-1:0]    o_front_value,
    output logic [bde_pkg::WORD_W-1:0]    o_rear_value,
    output logic [bde_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_is_empty,
    output logic                          o_is_full
);
    import bde_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GET   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_STF   = 3'd4;
    localparam logic [2:0] S_STR   = 3'd5;
    localparam logic [2:0] S_STD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_fp, n_fp;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;

    logic [KIND_W-1:0]  r_kind, n_kind;
    t_elem              r_key, n_key;
    logic [COUNT_W-1:0] r_i, n_i;
    logic               r_cmp_valid, n_cmp_valid;
    logic [COUNT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [COUNT_W-1:0] r_j, n_j;
    logic               r_ok, n_ok;
    t_elem              r_rd, n_rd;
    t_elem              r_fv, n_fv;
    t_elem              r_rv, n_rv;

    logic               r_o_ok;
    t_elem              r_o_rd, r_o_fv, r_o_rv;
    logic [COUNT_W-1:0] r_o_cnt;
    logic               w_load;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_elem              ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    t_elem              ram_rdata;

    logic               w_hit;
    logic [COUNT_W:0]   w_next1;
    logic [COUNT_W:0]   w_j2;
    logic               w_room;
    logic               w_idx_in;

    bde_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_hit    = r_cmp_valid && (ram_rdata == r_key);
    assign w_next1  = {1'b0, r_cmp_idx} + 1'b1;
    assign w_j2     = {1'b0, r_j} + 2'd2;
    assign w_room   = (r_cnt < COUNT_W'(DEPTH));
    assign w_idx_in = (CMP_W'(i_cmd.index) < CMP_W'(r_cnt));

    always_comb begin
        n_state     = r_state;
        n_fp        = r_fp;
        n_cnt       = r_cnt;
        n_kind      = r_kind;
        n_key       = r_key;
        n_i         = r_i;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_j         = r_j;
        n_ok        = r_ok;
        n_rd        = r_rd;
        n_fv        = r_fv;
        n_rv        = r_rv;
        o_cmd_take  = 1'b0;
        w_load      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_fp;
        ram_wdata   = r_key;
        ram_raddr   = r_fp;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take  = 1'b1;
                    n_kind      = i_cmd.kind;
                    n_key       = i_cmd.key;
                    n_ok        = 1'b0;
                    n_rd        = '0;
                    n_i         = '0;
                    n_cmp_valid = 1'b0;
                    n_state     = S_STF;
                    if (i_cmd.scan) begin
                        n_state = S_SCAN;
                    end else begin
                        unique case (i_cmd.kind)
                            KIND_PUSH_FRONT: begin
                                if (w_room) begin
                                    n_fp      = ring_dec(r_fp);
                                    ram_we    = 1'b1;
                                    ram_waddr = ring_dec(r_fp);
                                    ram_wdata = i_cmd.key;
                                    n_cnt     = r_cnt + 1'b1;
                                    n_ok      = 1'b1;
                                end
                            end
                            KIND_PUSH_REAR: begin
                                if (w_room) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = ring_add(r_fp, r_cnt);
                                    ram_wdata = i_cmd.key;
                                    n_cnt     = r_cnt + 1'b1;
                                    n_ok      = 1'b1;
                                end
                            end
                            KIND_POP_FRONT: begin
                                if (r_cnt != '0) begin
                                    n_fp  = ring_add(r_fp, COUNT_W'(1));
                                    n_cnt = r_cnt - 1'b1;
                                    n_ok  = 1'b1;
                                end
                            end
                            KIND_POP_REAR: begin
                                if (r_cnt != '0) begin
                                    n_cnt = r_cnt - 1'b1;
                                    n_ok  = 1'b1;
                                end
                            end
                            KIND_GET: begin
                                if (w_idx_in) begin
                                    ram_raddr = ring_add(r_fp, COUNT_W'(i_cmd.index));
                                    n_ok      = 1'b1;
                                    n_state   = S_GET;
                                end
                            end
                            default: begin
                                // query, and the scan kinds handled above
                                n_ok = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_GET: begin
                n_rd    = ram_rdata;
                n_state = S_STF;
            end
            S_SCAN: begin
                // read of position i issued while position i-1 is compared
                if (w_hit) begin
                    n_ok = 1'b1;
                    if (r_kind == KIND_REMOVE) begin
                        if (w_next1 < (COUNT_W + 1)'(r_cnt)) begin
                            ram_raddr = ring_add(r_fp, COUNT_W'(w_next1));
                            n_j       = r_cmp_idx;
                            n_state   = S_SHIFT;
                        end else begin
                            n_cnt   = r_cnt - 1'b1;
                            n_state = S_STF;
                        end
                    end else begin
                        n_state = S_STF;
                    end
                end else if (r_i < r_cnt) begin
                    ram_raddr   = ring_add(r_fp, r_i);
                    n_i         = r_i + 1'b1;
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_i;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_STF;
                end
            end
            S_SHIFT: begin
                // element j+1 arrives and moves one place toward the front
                ram_we    = 1'b1;
                ram_waddr = ring_add(r_fp, r_j);
                ram_wdata = ram_rdata;
                if (w_j2 < (COUNT_W + 1)'(r_cnt)) begin
                    ram_raddr = ring_add(r_fp, COUNT_W'(w_j2));
                    n_j       = r_j + 1'b1;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_STF;
                end
            end
            S_STF: begin
                if (r_cnt == '0) begin
                    n_fv    = '0;
                    n_rv    = '0;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_fp;
                    n_state   = S_STR;
                end
            end
            S_STR: begin
                n_fv      = ram_rdata;
                ram_raddr = ring_add(r_fp, r_cnt - 1'b1);
                n_state   = S_STD;
            end
            S_STD: begin
                n_rv    = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fp        <= n_fp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_i         <= n_i;
        r_cmp_valid <= n_cmp_valid;
        r_cmp_idx   <= n_cmp_idx;
        r_j         <= n_j;
        r_ok        <= n_ok;
        r_rd        <= n_rd;
        r_fv        <= n_fv;
        r_rv        <= n_rv;
        if (w_load) begin
            r_o_ok  <= r_ok;
            r_o_rd  <= r_rd;
            r_o_fv  <= r_fv;
            r_o_rv  <= r_rv;
            r_o_cnt <= r_cnt;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_ok          = r_o_ok;
    assign o_read_value  = to_word(r_o_rd);
    assign o_front_value = to_word(r_o_fv);
    assign o_rear_value  = to_word(r_o_rv);
    assign o_count       = r_o_cnt;
    assign o_is_empty    = (r_o_cnt == '0);
    assign o_is_full     = (r_o_cnt == COUNT_W'(DEPTH));

endmodule

FILE: hdl/bounded_deque_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_engine_unit
// Bounded double-ended queue kept as a ring in a slot RAM: push/pop at both
// ends, remove-by-value with gap closing, find, get by position, query.
//
//   channel   handshake            payload
//   request   push / full          i_kind, i_value, i_index
//   result    empty / pop          o_ok, o_read_value, o_front_value,
//                                  o_rear_value, o_count, o_is_empty, o_is_full
//
// Push, pop, get and query pass through the sequencer, which then fetches front
// and rear with registered RAM reads after each operation.
// Find and remove first scan the stored elements; remove then closes the gap,
// one element moved per cycle. A two-entry command queue takes requests
// while the sequencer works and a finished result waits in its register.
// Synchronous active-low reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_deque_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bde_pkg::KIND_W-1:0]    i_kind,
    input  logic [bde_pkg::WORD_W-1:0]    i_value,
    input  logic [bde_pkg::INDEX_W-1:0]   i_index,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_ok,
    output logic [bde_pkg::WORD_W-1:0]    o_read_value,
    output logic [bde_pkg::WORD_W-1:0]    o_front_value,
    output logic [bde_pkg::WORD_W-1:0]    o_rear_value,
    output logic [bde_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_is_empty,
    output logic                          o_is_full
);
    import bde_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    bde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    bde_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_take    (cmd_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_ok          (o_ok),
        .o_read_value  (o_read_value),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

endmodule
